FILE: design/awpr_pkg.sv
// Package for the Ackermann wheel pulse rate block.
// Holds register indexes, fixed widths and constants shared by all files.
// No dependencies.
`timescale 1ns / 1ps

package awpr_pkg;

    localparam int DUTY_W     = 10;
    localparam int SPEED_W    = 16;
    localparam int LEN_W      = 16;
    localparam int ANGLE_W    = 14;
    localparam int GAIN_W     = 24;
    localparam int FREQ_W     = 20;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_WHEELBASE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 8'd3;

    localparam logic [LEN_W-1:0]   WHEELBASE_RESET = 16'd2500;
    localparam logic [LEN_W-1:0]   TRACK_RESET     = 16'd1500;
    localparam logic [ANGLE_W-1:0] MAX_ANGLE_RESET = 14'd2910;
    localparam logic [GAIN_W-1:0]  GAIN_RESET      = 24'd65536;

    // Wheel numerator slots, inner/outer side.
    localparam int WHEEL_IN_REAR   = 0;
    localparam int WHEEL_IN_FRONT  = 1;
    localparam int WHEEL_OUT_REAR  = 2;
    localparam int WHEEL_OUT_FRONT = 3;
    localparam int NUM_WHEELS      = 4;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [DUTY_W-1:0] DUTY_CENTER = 10'd500;
    localparam logic [ANGLE_W-1:0] RIGHT_ANGLE = 14'd9000;

    // Quotient bits kept by the divider; anything at or above 2^40 saturates.
    localparam int QUOT_W  = 40;
    localparam int DIV_LAT = QUOT_W + 1;

    localparam logic [FREQ_W-1:0] FREQ_MAX = 20'hFFFFF;

    typedef struct packed {
        logic              ovf;
        logic [QUOT_W-1:0] quot;
    } awpr_quot_t;

    typedef struct packed {
        logic [FREQ_W-1:0] left_front;
        logic [FREQ_W-1:0] left_rear;
        logic [FREQ_W-1:0] right_front;
        logic [FREQ_W-1:0] right_rear;
        logic              sat;
    } awpr_result_t;

endpackage

FILE: design/awpr_ifs.sv
// Handshake interfaces for the Ackermann wheel pulse rate block.
// Depends on awpr_pkg for field widths.
`timescale 1ns / 1ps

interface awpr_sample_if;
    import awpr_pkg::*;
    logic               valid;
    logic               ready;
    logic [DUTY_W-1:0]  steering_duty;
    logic [SPEED_W-1:0] car_speed;
    modport source (output valid, steering_duty, car_speed, input ready);
    modport sink (input valid, steering_duty, car_speed, output ready);
endinterface

interface awpr_rates_if;
    import awpr_pkg::*;
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] left_front_freq;
    logic [FREQ_W-1:0] left_rear_freq;
    logic [FREQ_W-1:0] right_front_freq;
    logic [FREQ_W-1:0] right_rear_freq;
    logic              saturated;
    modport source (output valid, left_front_freq, left_rear_freq, right_front_freq,
                    right_rear_freq, saturated, input ready);
    modport sink (input valid, left_front_freq, left_rear_freq, right_front_freq,
                  right_rear_freq, saturated, output ready);
endinterface

interface awpr_cfg_if;
    import awpr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: design/awpr_geom.sv
// Front pipeline: steering duty to angle, sine table lookup, Ackermann
// numerators and the scaled dividends for the wheel dividers. Uses awpr_pkg.
`timescale 1ns / 1ps

module awpr_geom
    import awpr_pkg::*;
#(
    parameter int SINCOS_TABLE_DEPTH = 256,
    parameter int TRIG_FRAC_BITS     = 16,
    parameter int NUM_W              = TRIG_FRAC_BITS + 19,
    parameter int XW                 = NUM_W + 17
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [DUTY_W-1:0]                    steering_duty,
    input  logic [SPEED_W-1:0]                   car_speed,
    input  logic [LEN_W-1:0]                     wheelbase,
    input  logic [LEN_W-1:0]                     track,
    input  logic [ANGLE_W-1:0]                   max_angle,
    output logic                                 out_valid,
    output logic                                 out_right_inner,
    output logic [SPEED_W-1:0]                   out_speed,
    output logic [NUM_W-1:0]                     out_den,
    output logic [NUM_WHEELS-1:0][XW-1:0]        out_dividend
);

    localparam int TRIG_W   = TRIG_FRAC_BITS + 1;
    localparam int LC_W     = LEN_W + TRIG_W;
    localparam int IDX_W    = $clog2(SINCOS_TABLE_DEPTH + 1);
    localparam int V2_W     = $clog2(9000 * SINCOS_TABLE_DEPTH + 4501);
    localparam int P2_W     = V2_W + 26;
    localparam int LO_W     = 22;
    localparam int HI_W     = NUM_W - LO_W;
    localparam int P1_W     = 24;
    // Angle rounding: divide by 450 through a reciprocal, exact below the clamp.
    localparam logic [23:0] RECIP_450  = 24'((64'd1 << 32) / 450 + 1);
    localparam logic [P1_W-1:0] P1_SAT = 24'd4050000;
    // Index rounding: divide by 9000 through a reciprocal with a 39 bit shift.
    localparam logic [25:0] RECIP_9000 = 26'(((64'd1 << 39) + 64'd8999) / 9000);

    typedef logic [SINCOS_TABLE_DEPTH:0][TRIG_W-1:0] sine_tbl_t;

    function automatic sine_tbl_t build_sine();
        sine_tbl_t          tbl;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        rnd;
        logic signed [63:0] sum;
        int                 k;
        for (int i = 0; i <= SINCOS_TABLE_DEPTH; i++) begin
            x = (64'(i) * PI_Q30 + 64'(SINCOS_TABLE_DEPTH)) / 64'(2 * SINCOS_TABLE_DEPTH);
            x2 = (x * x) >> 30;
            term = x;
            sum = $signed(x);
            for (k = 1; k <= 12; k++) begin
                term = (term * x2) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                if (k[0])
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
            if (sum < 0)
                sum = 0;
            rnd = (64'(sum) + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
            tbl[i] = (rnd > (64'd1 << TRIG_FRAC_BITS)) ? TRIG_W'(64'd1 << TRIG_FRAC_BITS)
                                                        : TRIG_W'(rnd);
        end
        return tbl;
    endfunction

    localparam sine_tbl_t SINE_TBL = build_sine();

    logic [8:0]                    valid_reg;
    logic [8:0][SPEED_W-1:0]       speed_reg;
    logic [8:0]                    ri_reg;

    logic [P1_W-1:0]               p1_reg;
    logic [ANGLE_W-1:0]            mag_reg;
    logic [V2_W-1:0]               v2_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic [TRIG_W-1:0]             sin_reg;
    logic [TRIG_W-1:0]             cos_reg;
    logic [LC_W-1:0]               lc_reg;
    logic [LC_W-1:0]               ts_reg;
    logic [NUM_W-1:0]              den6_reg;
    logic [NUM_WHEELS-1:0][NUM_W-1:0] num_reg;
    logic [NUM_W-1:0]              den7_reg;
    logic [NUM_WHEELS-1:0][SPEED_W+LO_W-1:0] plo_reg;
    logic [NUM_WHEELS-1:0][SPEED_W+HI_W-1:0] phi_reg;
    logic [NUM_W-1:0]              den8_reg;
    logic [NUM_WHEELS-1:0][XW-1:0] x_reg;

    logic                          right_next;
    logic [DUTY_W-1:0]             dev;
    logic [P1_W-1:0]               p1_next;
    logic [45:0]                   q450;
    logic [ANGLE_W-1:0]            mag_next;
    logic [V2_W-1:0]               v2_next;
    logic [P2_W-1:0]               p2;
    logic [P2_W-1:0]               idx_full;
    logic [IDX_W-1:0]              idx_next;
    logic [LC_W-1:0]               lf_shift;

    always_comb
    begin
        right_next = steering_duty > DUTY_CENTER;
        dev = right_next ? steering_duty - DUTY_CENTER : DUTY_CENTER - steering_duty;
        p1_next = P1_W'(dev) * P1_W'(max_angle) + P1_W'(225);
        q450 = 46'(p1_reg[21:0]) * 46'(RECIP_450);
        mag_next = (p1_reg >= P1_SAT) ? RIGHT_ANGLE : q450[45:32];
        v2_next = V2_W'(mag_reg) * V2_W'(SINCOS_TABLE_DEPTH) + V2_W'(4500);
        p2 = P2_W'(v2_reg) * P2_W'(RECIP_9000);
        idx_full = p2 >> 39;
        idx_next = (idx_full > P2_W'(SINCOS_TABLE_DEPTH)) ? IDX_W'(SINCOS_TABLE_DEPTH)
                                                           : idx_full[IDX_W-1:0];
        lf_shift = LC_W'(wheelbase) << TRIG_FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[7:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            speed_reg <= {speed_reg[7:0], car_speed};
            ri_reg    <= {ri_reg[7:0], right_next};
            p1_reg    <= p1_next;
            mag_reg   <= mag_next;
            v2_reg    <= v2_next;
            idx_reg   <= idx_next;
            sin_reg   <= SINE_TBL[idx_reg];
            cos_reg   <= SINE_TBL[IDX_W'(SINCOS_TABLE_DEPTH) - idx_reg];
            lc_reg    <= LC_W'(wheelbase) * LC_W'(cos_reg);
            ts_reg    <= LC_W'(track) * LC_W'(sin_reg);
            den6_reg  <= (NUM_W'(lc_reg) << 1) + NUM_W'(ts_reg);
            num_reg[WHEEL_IN_REAR]   <= NUM_W'(lc_reg) << 1;
            num_reg[WHEEL_IN_FRONT]  <= NUM_W'(lf_shift) << 1;
            num_reg[WHEEL_OUT_REAR]  <= (NUM_W'(lc_reg) + NUM_W'(ts_reg)) << 1;
            num_reg[WHEEL_OUT_FRONT] <= (NUM_W'(lf_shift) + NUM_W'(ts_reg)) << 1;
            den7_reg  <= den6_reg;
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                plo_reg[w] <= (SPEED_W+LO_W)'(speed_reg[6]) *
                              (SPEED_W+LO_W)'(num_reg[w][LO_W-1:0]);
                phi_reg[w] <= (SPEED_W+HI_W)'(speed_reg[6]) *
                              (SPEED_W+HI_W)'(num_reg[w][NUM_W-1:LO_W]);
                x_reg[w]   <= (XW'(phi_reg[w]) << LO_W) + XW'(plo_reg[w]) +
                              XW'(den7_reg >> 1);
            end
            den8_reg  <= den7_reg;
        end
    end

    assign out_valid       = valid_reg[8];
    assign out_right_inner = ri_reg[8];
    assign out_speed       = speed_reg[8];
    assign out_den         = den8_reg;
    assign out_dividend    = x_reg;

endmodule

FILE: design/awpr_div.sv
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow check at entry and a pass-through when the divisor is zero.
// Uses awpr_pkg.
`timescale 1ns / 1ps

module awpr_div
    import awpr_pkg::*;
#(
    parameter int XW = 52,
    parameter int DW = 35
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [XW-1:0]      dividend,
    input  logic [DW-1:0]      divisor,
    input  logic [SPEED_W-1:0] fallback,
    output logic               out_valid,
    output awpr_quot_t         result
);

    logic [QUOT_W:0]             valid_reg;
    logic [QUOT_W:0][DW-1:0]     rem_reg;
    logic [QUOT_W:0][QUOT_W-1:0] sh_reg;
    logic [QUOT_W:0][DW-1:0]     dvs_reg;
    logic [QUOT_W:0]             byp_reg;
    logic [QUOT_W:0]             ovf_reg;

    logic [QUOT_W:1][DW-1:0]     rem_next;
    logic [QUOT_W:1][QUOT_W-1:0] sh_next;
    logic                        zero_dvs;

    assign zero_dvs = (divisor == '0);

    always_comb
    begin
        for (int k = 1; k <= QUOT_W; k++)
        begin
            logic [DW:0] trial;
            logic        ge;
            trial = {rem_reg[k-1], sh_reg[k-1][QUOT_W-1]};
            ge = !byp_reg[k-1] && (trial >= {1'b0, dvs_reg[k-1]});
            rem_next[k] = ge ? DW'(trial - {1'b0, dvs_reg[k-1]}) : DW'(trial);
            sh_next[k] = byp_reg[k-1] ? sh_reg[k-1] : {sh_reg[k-1][QUOT_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[QUOT_W-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DW'(dividend[XW-1:QUOT_W]);
            sh_reg[0]  <= zero_dvs ? QUOT_W'(fallback) : dividend[QUOT_W-1:0];
            dvs_reg[0] <= divisor;
            byp_reg[0] <= zero_dvs;
            ovf_reg[0] <= !zero_dvs && (DW'(dividend[XW-1:QUOT_W]) >= divisor);
            for (int k = 1; k <= QUOT_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                sh_reg[k]  <= sh_next[k];
                dvs_reg[k] <= dvs_reg[k-1];
                byp_reg[k] <= byp_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign out_valid   = valid_reg[QUOT_W];
    assign result.quot = sh_reg[QUOT_W];
    assign result.ovf  = ovf_reg[QUOT_W];

endmodule

FILE: design/awpr_rate.sv
// Gain stage: wheel speed times pulse gain, rounded and saturated to a
// 20 bit pulse rate. Uses awpr_pkg.
`timescale 1ns / 1ps

module awpr_rate
    import awpr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  awpr_quot_t        speed,
    input  logic [GAIN_W-1:0] gain,
    output logic              out_valid,
    output logic [FREQ_W-1:0] freq,
    output logic              sat
);

    localparam int HALF_W = QUOT_W / 2;
    localparam int PROD_W = HALF_W + GAIN_W;

    logic              valid_reg;
    logic [PROD_W-1:0] ph_reg;
    logic [PROD_W-1:0] pl_reg;
    logic              ovf_reg;
    logic [PROD_W:0]   f_full;
    logic              gain_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // The wheel speed is split in two halves so each product stays narrow.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_reg  <= PROD_W'(speed.quot[QUOT_W-1:HALF_W]) * PROD_W'(gain);
            pl_reg  <= PROD_W'(speed.quot[HALF_W-1:0]) * PROD_W'(gain);
            ovf_reg <= speed.ovf;
        end
    end

    always_comb
    begin
        gain_zero = (gain == '0);
        f_full = (PROD_W+1)'(ph_reg) +
                 (PROD_W+1)'((pl_reg + (PROD_W'(1) << (HALF_W - 1))) >> HALF_W);
        sat = !gain_zero && (ovf_reg || (f_full > (PROD_W+1)'(FREQ_MAX)));
        if (gain_zero)
            freq = '0;
        else if (sat)
            freq = FREQ_MAX;
        else
            freq = f_full[FREQ_W-1:0];
    end

    assign out_valid = valid_reg;

endmodule

FILE: design/ackermann_wheel_pulse_rates_top.sv
// Top level of the Ackermann wheel pulse rate block: configuration
// registers, geometry pipeline, four wheel dividers, gain stages and output.
// Depends on awpr_pkg, awpr_ifs, awpr_geom, awpr_div and awpr_rate.
`timescale 1ns / 1ps

//  Channel  Role   Moves per transfer
//  -------  -----  -------------------------------------------------------
//  sample   sink   steering_duty, car_speed
//  rates    source left/right front/rear pulse rates, saturated flag
//  cfg      sink   register index and write data
//
// One sample transfer is accepted every cycle while the skid register is empty;
// each yields one rates transfer after 9 geometry stages, 41 divider stages (an entry stage with
// the overflow check, then one quotient bit per stage for 40 bits), one gain
// stage and the output register.
// Reset clears all valid bits and sets the registers to their defaults.
// A stall on rates parks one finished result in a skid register; the whole
// pipeline then holds until the output register is taken, so nothing is lost.

module ackermann_wheel_pulse_rates_top
    import awpr_pkg::*;
#(
    parameter int SINCOS_TABLE_DEPTH = 256,
    parameter int TRIG_FRAC_BITS     = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    awpr_sample_if.sink   sample,
    awpr_rates_if.source  rates,
    awpr_cfg_if.sink      cfg
);

    // Numerators and the common denominator carry twice their value.
    localparam int NUM_W = TRIG_FRAC_BITS + 19;
    localparam int XW    = NUM_W + 17;
    localparam int RI_LAT = DIV_LAT + 1;

    logic [LEN_W-1:0]   wheelbase_reg;
    logic [LEN_W-1:0]   track_reg;
    logic [ANGLE_W-1:0] max_angle_reg;
    logic [GAIN_W-1:0]  gain_reg;

    // Configuration is always accepted; indexes beyond the list are ignored.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheelbase_reg <= WHEELBASE_RESET;
            track_reg     <= TRACK_RESET;
            max_angle_reg <= MAX_ANGLE_RESET;
            gain_reg      <= GAIN_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_WHEELBASE: wheelbase_reg <= cfg.data[LEN_W-1:0];
                CFG_TRACK:     track_reg     <= cfg.data[LEN_W-1:0];
                CFG_MAX_ANGLE: max_angle_reg <= cfg.data[ANGLE_W-1:0];
                CFG_GAIN:      gain_reg      <= cfg.data[GAIN_W-1:0];
                default:       ;
            endcase
        end
    end

    // The whole pipeline advances together whenever the skid register is
    // empty. The enable comes from a register, so there is no combinational
    // path from rates.ready back to sample.ready.
    logic         skid_valid_reg;
    logic         skid_valid_next;
    awpr_result_t skid_data_reg;
    awpr_result_t skid_data_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    awpr_result_t out_data_reg;
    awpr_result_t out_data_next;
    logic         en;

    assign en = !skid_valid_reg;
    assign sample.ready = en;

    logic                           geo_valid;
    logic                           geo_right_inner;
    logic [SPEED_W-1:0]             geo_speed;
    logic [NUM_W-1:0]               geo_den;
    logic [NUM_WHEELS-1:0][XW-1:0]  geo_dividend;

    awpr_geom #(
        .SINCOS_TABLE_DEPTH (SINCOS_TABLE_DEPTH),
        .TRIG_FRAC_BITS     (TRIG_FRAC_BITS),
        .NUM_W              (NUM_W),
        .XW                 (XW)
    ) u_geom (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (sample.valid),
        .steering_duty   (sample.steering_duty),
        .car_speed       (sample.car_speed),
        .wheelbase       (wheelbase_reg),
        .track           (track_reg),
        .max_angle       (max_angle_reg),
        .out_valid       (geo_valid),
        .out_right_inner (geo_right_inner),
        .out_speed       (geo_speed),
        .out_den         (geo_den),
        .out_dividend    (geo_dividend)
    );

    logic [NUM_WHEELS-1:0]              div_valid;
    awpr_quot_t [NUM_WHEELS-1:0]        div_result;
    logic [NUM_WHEELS-1:0]              rate_valid;
    logic [NUM_WHEELS-1:0][FREQ_W-1:0]  rate_freq;
    logic [NUM_WHEELS-1:0]              rate_sat;

    // Each wheel gets its own divider and gain stage; all four run in lockstep.
    for (genvar w = 0; w < NUM_WHEELS; w++)
    begin : g_wheel
        awpr_div #(
            .XW (XW),
            .DW (NUM_W)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (geo_valid),
            .dividend  (geo_dividend[w]),
            .divisor   (geo_den),
            .fallback  (geo_speed),
            .out_valid (div_valid[w]),
            .result    (div_result[w])
        );

        awpr_rate u_rate (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (div_valid[w]),
            .speed     (div_result[w]),
            .gain      (gain_reg),
            .out_valid (rate_valid[w]),
            .freq      (rate_freq[w]),
            .sat       (rate_sat[w])
        );
    end

    // The steering side only decides the final wheel order, so it rides
    // alongside the dividers and gain stages in a plain delay line.
    logic [RI_LAT-1:0] ri_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ri_reg <= {ri_reg[RI_LAT-2:0], geo_right_inner};
        end
    end

    awpr_result_t pipe_data;
    logic         pipe_valid;

    always_comb
    begin
        pipe_valid = rate_valid[WHEEL_IN_REAR];
        pipe_data.sat = |rate_sat;
        if (ri_reg[RI_LAT-1])
        begin
            pipe_data.left_front  = rate_freq[WHEEL_OUT_FRONT];
            pipe_data.left_rear   = rate_freq[WHEEL_OUT_REAR];
            pipe_data.right_front = rate_freq[WHEEL_IN_FRONT];
            pipe_data.right_rear  = rate_freq[WHEEL_IN_REAR];
        end
        else
        begin
            pipe_data.left_front  = rate_freq[WHEEL_IN_FRONT];
            pipe_data.left_rear   = rate_freq[WHEEL_IN_REAR];
            pipe_data.right_front = rate_freq[WHEEL_OUT_FRONT];
            pipe_data.right_rear  = rate_freq[WHEEL_OUT_REAR];
        end
    end

    // Output register with one skid entry behind it.
    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        if (skid_valid_reg)
        begin
            if (rates.ready)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (pipe_valid)
        begin
            if (out_valid_reg && !rates.ready)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = pipe_data;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_data_next  = pipe_data;
            end
        end
        else if (rates.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        skid_data_reg <= skid_data_next;
        out_data_reg  <= out_data_next;
    end

    assign rates.valid            = out_valid_reg;
    assign rates.left_front_freq  = out_data_reg.left_front;
    assign rates.left_rear_freq   = out_data_reg.left_rear;
    assign rates.right_front_freq = out_data_reg.right_front;
    assign rates.right_rear_freq  = out_data_reg.right_rear;
    assign rates.saturated        = out_data_reg.sat;

    // The skid entry only fills when a result could not leave the output.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(rates.valid && !rates.ready))
        else $error("skid register filled without an output stall");

    // A parked result implies the output register is also occupied.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> (rates.valid && !sample.ready))
        else $error("skid register holds data ahead of the output");

    // Any clamped rate shows up as full scale on at least one wheel.
    a_sat_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (rates.valid && rates.saturated) |->
        (rates.left_front_freq == FREQ_MAX || rates.left_rear_freq == FREQ_MAX ||
         rates.right_front_freq == FREQ_MAX || rates.right_rear_freq == FREQ_MAX))
        else $error("saturated flag set with no rate at full scale");

endmodule

FILE: tb/sv/tb_ackermann_wheel_pulse_rates_top.sv
// Self-checking testbench for ackermann_wheel_pulse_rates_top: directed,
// register-setting, random and backpressure tests against an internal predictor.
// Depends on awpr_pkg, awpr_ifs and the block's RTL.
`timescale 1ns / 1ps

module tb_ackermann_wheel_pulse_rates_top;
    import awpr_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int FRAC_BITS   = 16;
    // A margin beyond the block's latency is added for drains.
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 660;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd7;
    localparam longint unsigned SPEED_CAP = 64'd1 << 40;

    logic clk;
    logic rst_n;

    awpr_sample_if sample_ch ();
    awpr_rates_if  rates_ch ();
    awpr_cfg_if    cfg_ch ();

    ackermann_wheel_pulse_rates_top #(
        .SINCOS_TABLE_DEPTH(TABLE_DEPTH),
        .TRIG_FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample_ch.sink),
        .rates(rates_ch.source),
        .cfg(cfg_ch.sink)
    );

    // Local copy of the configuration registers, updated at each cfg transfer.
    longint unsigned wheelbase;
    longint unsigned track;
    longint unsigned max_angle;
    longint unsigned gain;

    // Quarter-wave sine table, built once with the same truncating series.
    longint unsigned sine_tab [0:TABLE_DEPTH];

    awpr_result_t pending_rates [$];

    int errors;
    int items_sent;
    int results_seen;
    int saturated_seen;
    int cycle_count;

    // Idle percentages of the sample sender and the rates receiver.
    int tx_idle_pct;
    int rx_idle_pct;
    // Remaining cycles of a forced long stall on rates.
    int hold_left;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint unsigned sine_point(longint unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint signed   acc;
        longint unsigned r;
        longint unsigned one;
        x = (i * PI_Q30 + TABLE_DEPTH) / (2 * TABLE_DEPTH);
        x2 = (x * x) >> 30;
        term = x;
        acc = x;
        one = 64'd1 << FRAC_BITS;
        for (int k = 1; k <= 12; k++)
        begin
            term = (term * x2) >> 30;
            term = term / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        r = (longint'(acc) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        return (r > one) ? one : r;
    endfunction

    // One wheel: speed scaled by num/den, then by the gain, saturating.
    function automatic logic [FREQ_W-1:0] wheel_freq(longint unsigned speed,
                                                     longint unsigned num2,
                                                     longint unsigned den2,
                                                     inout logic sat);
        longint unsigned w;
        longint unsigned f;
        if (den2 == 0)
            w = speed;
        else
            w = (speed * num2 + den2 / 2) / den2;
        if (gain == 0)
            return '0;
        if (w >= SPEED_CAP)
        begin
            sat = 1'b1;
            return FREQ_MAX;
        end
        f = (w * gain + (64'd1 << 19)) >> 20;
        if (f > FREQ_MAX)
        begin
            sat = 1'b1;
            return FREQ_MAX;
        end
        return f[FREQ_W-1:0];
    endfunction

    function automatic awpr_result_t predict_rates(logic [DUTY_W-1:0] duty,
                                                   logic [SPEED_W-1:0] speed);
        awpr_result_t    res;
        logic            right_inner;
        logic            sat;
        longint unsigned dev;
        longint unsigned mag;
        longint unsigned idx;
        longint unsigned s;
        longint unsigned c;
        longint unsigned lc;
        longint unsigned ts;
        longint unsigned lw;
        longint unsigned den;
        logic [FREQ_W-1:0] in_rear;
        logic [FREQ_W-1:0] in_front;
        logic [FREQ_W-1:0] out_rear;
        logic [FREQ_W-1:0] out_front;
        right_inner = duty > DUTY_CENTER;
        dev = right_inner ? duty - DUTY_CENTER : DUTY_CENTER - duty;
        sat = 1'b0;
        mag = (dev * max_angle + 225) / 450;
        if (mag > RIGHT_ANGLE)
            mag = RIGHT_ANGLE;
        idx = (mag * TABLE_DEPTH + RIGHT_ANGLE / 2) / RIGHT_ANGLE;
        if (idx > TABLE_DEPTH)
            idx = TABLE_DEPTH;
        s = sine_tab[idx];
        c = sine_tab[TABLE_DEPTH - idx];
        lc = wheelbase * c;
        ts = track * s;
        lw = wheelbase << FRAC_BITS;
        den = 2 * lc + ts;
        in_rear   = wheel_freq(speed, 2 * lc, den, sat);
        in_front  = wheel_freq(speed, 2 * lw, den, sat);
        out_rear  = wheel_freq(speed, 2 * (lc + ts), den, sat);
        out_front = wheel_freq(speed, 2 * (lw + ts), den, sat);
        if (right_inner)
        begin
            res.left_front  = out_front;
            res.left_rear   = out_rear;
            res.right_front = in_front;
            res.right_rear  = in_rear;
        end
        else
        begin
            res.left_front  = in_front;
            res.left_rear   = in_rear;
            res.right_front = out_front;
            res.right_rear  = out_rear;
        end
        res.sat = sat;
        return res;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got,
                                   longint unsigned want);
        $display("MISMATCH %s: got %0d expected %0d (result %0d, cycle %0d)",
                 field, got, want, results_seen, cycle_count);
        errors++;
    endtask

    // Result checker: every rates transfer is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rates_ch.valid && rates_ch.ready)
        begin
            if (pending_rates.size() == 0)
            begin
                report_mismatch("unexpected rates transfer, count",
                                longint'(results_seen) + 1, longint'(items_sent));
            end
            else
            begin
                awpr_result_t want;
                want = pending_rates.pop_front();
                if (rates_ch.left_front_freq !== want.left_front)
                    report_mismatch("left_front_freq", rates_ch.left_front_freq,
                                    want.left_front);
                if (rates_ch.left_rear_freq !== want.left_rear)
                    report_mismatch("left_rear_freq", rates_ch.left_rear_freq,
                                    want.left_rear);
                if (rates_ch.right_front_freq !== want.right_front)
                    report_mismatch("right_front_freq", rates_ch.right_front_freq,
                                    want.right_front);
                if (rates_ch.right_rear_freq !== want.right_rear)
                    report_mismatch("right_rear_freq", rates_ch.right_rear_freq,
                                    want.right_rear);
                if (rates_ch.saturated !== want.sat)
                    report_mismatch("saturated", rates_ch.saturated, want.sat);
                if (want.sat)
                    saturated_seen++;
            end
            results_seen++;
        end
    end

    // Rates receiver. A forced stall is counted down here; otherwise ready is
    // dropped at random according to the current idle percentage.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rates_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            rates_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_rates.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offers one sample, with a random idle gap first, and records the
    // prediction once the transfer happens. Valid stays high afterwards so
    // back-to-back items stream; the next idle gap or a drop lowers it.
    task automatic send_sample(logic [DUTY_W-1:0] duty, logic [SPEED_W-1:0] speed);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.steering_duty <= duty;
        sample_ch.car_speed <= speed;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        pending_rates.push_back(predict_rates(duty, speed));
        items_sent++;
    endtask

    task automatic drop_sample_valid();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
    endtask

    // Waits until every predicted result has arrived, then lets the
    // pipeline run empty before anything touches the registers.
    task automatic wait_drained();
        drop_sample_valid();
        while (pending_rates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_WHEELBASE: wheelbase = value[LEN_W-1:0];
            CFG_TRACK:     track     = value[LEN_W-1:0];
            CFG_MAX_ANGLE: max_angle = value[ANGLE_W-1:0];
            CFG_GAIN:      gain      = value[GAIN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_geometry(logic [CFG_DATA_W-1:0] wb, logic [CFG_DATA_W-1:0] tr,
                                  logic [CFG_DATA_W-1:0] ang, logic [CFG_DATA_W-1:0] g);
        write_register(CFG_WHEELBASE, wb);
        write_register(CFG_TRACK, tr);
        write_register(CFG_MAX_ANGLE, ang);
        write_register(CFG_GAIN, g);
    endtask

    // Steering sweep covering both sides, straight ahead and the duty extremes.
    task automatic send_steering_sweep(logic [SPEED_W-1:0] speed);
        send_sample(10'd0, speed);
        send_sample(10'd499, speed);
        send_sample(DUTY_CENTER, speed);
        send_sample(10'd501, speed);
        send_sample(10'd1000, speed);
        send_sample(10'd1023, speed);
    endtask

    // Reset defaults: both sides, straight, zero and full speed.
    task automatic test_reset_defaults();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_steering_sweep(16'hFFFF);
        send_sample(DUTY_CENTER, 16'd0);
        send_sample(10'd750, 16'd1);
        send_sample(10'd250, 16'd25600);
        wait_drained();
    endtask

    // Register extremes and the geometric special cases.
    task automatic test_register_extremes();
        // Zero track at a right angle: the denominator vanishes at full lock.
        write_geometry(32'd1, 32'd0, 32'd9000, 32'd65536);
        send_steering_sweep(16'hFFFF);
        wait_drained();
        // Zero wheelbase when straight, and an angle limit above 90 degrees.
        write_geometry(32'd0, 32'hFFFF, 32'h3FFF, 32'd1);
        send_steering_sweep(16'h8000);
        wait_drained();
        // Zero gain gives all-zero rates.
        write_register(CFG_GAIN, 32'd0);
        send_sample(10'd1000, 16'hFFFF);
        wait_drained();
        // High data bits are dropped and an unknown index is ignored.
        write_geometry(32'hABCD_FFFF, 32'h1234_0001, 32'hFFFF_C000, 32'hFFFF_FFFF);
        write_register(CFG_UNUSED, 32'hFFFF_FFFF);
        send_steering_sweep(16'hFFFF);
        send_sample(DUTY_CENTER, 16'd3);
        wait_drained();
    endtask

    task automatic write_random_geometry();
        logic [CFG_DATA_W-1:0] g;
        case ($urandom_range(2))
            0: g = $urandom_range(32768, 131072);
            1: g = $urandom_range(0, 4096);
            default: g = $urandom;
        endcase
        write_geometry($urandom_range(1, 65535), $urandom_range(0, 65535),
                       ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 9000), g);
    endtask

    // Random items in blocks, each block under a fresh random geometry.
    task automatic test_random_traffic(int tx_idle, int rx_idle, int count);
        tx_idle_pct = tx_idle;
        rx_idle_pct = rx_idle;
        for (int b = 0; b < 4; b++)
        begin
            write_random_geometry();
            for (int n = 0; n < count / 4; n++)
                send_sample(DUTY_W'($urandom_range(0, 1023)), SPEED_W'($urandom));
            wait_drained();
        end
    endtask

    // Long stall on rates while samples keep coming, so the block fills and
    // stalls its input; then everything must drain in order.
    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_random_geometry();
        @(negedge clk);
        hold_left = 400;
        for (int n = 0; n < 120; n++)
            send_sample(DUTY_W'($urandom_range(0, 1023)), SPEED_W'($urandom));
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        saturated_seen = 0;
        cycle_count = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_left = 0;
        sample_ch.valid = 1'b0;
        sample_ch.steering_duty = '0;
        sample_ch.car_speed = '0;
        rates_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        wheelbase = WHEELBASE_RESET;
        track = TRACK_RESET;
        max_angle = MAX_ANGLE_RESET;
        gain = GAIN_RESET;
        for (int i = 0; i <= TABLE_DEPTH; i++)
            sine_tab[i] = sine_point(i);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_random_traffic(15, 75, RANDOM_ITEMS / 3);
        test_random_traffic(75, 15, RANDOM_ITEMS / 3);
        test_random_traffic(0, 0, RANDOM_ITEMS / 3);
        test_output_stall();

        $display("Covered reset defaults, register extremes, random traffic under three");
        $display("idle mixes and a long output stall: %0d items, %0d results, %0d saturated",
                 items_sent, results_seen, saturated_seen);
        if (errors == 0 && pending_rates.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
